// ----- hdl/ocb_pkg.sv -----
// Oklab color blend package: default sizes, matrix coefficients and the
// elaboration-time functions that build the transfer-curve tables.
// No dependencies.
package ocb_pkg;

   localparam int CHANNEL_BITS_DEF = 8;
   localparam int RATIO_BITS_DEF   = 8;
   localparam int FRAC_BITS_DEF    = 16;

   // integer bits (with sign) carried by pipeline values and coefficients
   localparam int VAL_INT_BITS  = 8;
   localparam int COEF_INT_BITS = 5;

   // matrix selectors
   localparam int MAT_TO_LMS     = 0;
   localparam int MAT_TO_LAB     = 1;
   localparam int MAT_LAB_TO_LMS = 2;
   localparam int MAT_LMS_TO_RGB = 3;

   // coefficients in units of 1e-10
   localparam longint TO_LMS_C [9] = '{
      64'sd4122214708, 64'sd5363325363, 64'sd514459929,
      64'sd2119034982, 64'sd6806995451, 64'sd1073969566,
      64'sd883024619, 64'sd2817188376, 64'sd6299787005};
   localparam longint TO_LAB_C [9] = '{
      64'sd2104542553, 64'sd7936177850, -64'sd40720468,
      64'sd19779984951, -64'sd24285922050, 64'sd4505937099,
      64'sd259040371, 64'sd7827717662, -64'sd8086757660};
   localparam longint LAB_TO_LMS_C [9] = '{
      64'sd10000000000, 64'sd3963377774, 64'sd2158037573,
      64'sd10000000000, -64'sd1055613458, -64'sd638541728,
      64'sd10000000000, -64'sd894841775, -64'sd12914855480};
   localparam longint LMS_TO_RGB_C [9] = '{
      64'sd40767416621, -64'sd33077115913, 64'sd2309699292,
      -64'sd12684380046, 64'sd26097574011, -64'sd3413193965,
      -64'sd41960863, -64'sd7034186147, 64'sd17076147010};

   localparam longint Q30_ONE = 64'sd1 <<< 30;

   // floor quotient of non-negative operands by shift and subtract
   function automatic longint udiv(input longint n, input longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
         r = (r <<< 1) | ((n >>> i) & 64'sd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'sd1 <<< i);
         end
      end
      return q;
   endfunction

   function automatic longint coef_q(input int mat, input int idx, input int frac);
      longint c;
      longint a;
      longint r;
      case (mat)
         MAT_TO_LMS:     c = TO_LMS_C[idx];
         MAT_TO_LAB:     c = TO_LAB_C[idx];
         MAT_LAB_TO_LMS: c = LAB_TO_LMS_C[idx];
         MAT_LMS_TO_RGB: c = LMS_TO_RGB_C[idx];
         default:        c = 0;
      endcase
      a = (c < 0) ? -c : c;
      r = udiv(a * (64'sd1 <<< frac) + 64'sd5000000000, 64'sd10000000000);
      return (c < 0) ? -r : r;
   endfunction

   // round half away from zero, then shift right
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic longint mul30(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic longint fifth_root30(input longint v);
      longint lo;
      longint hi;
      longint mid;
      longint p;
      lo = 0;
      hi = Q30_ONE;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 1) >>> 1);
         p = mul30(mul30(mul30(mul30(mid, mid), mid), mid), mid);
         if (p <= v) lo = mid; else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint cube_root30(input longint v);
      longint lo;
      longint hi;
      longint mid;
      longint sq;
      lo = 0;
      hi = Q30_ONE;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 1) >>> 1);
         sq = (mid * mid) >>> 30;
         if (((sq * mid) >>> 30) <= v) lo = mid; else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 64'sd4294967295;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 1) >>> 1);
         if (mid * mid <= v) lo = mid; else hi = mid - 1;
      end
      return lo;
   endfunction

   // sRGB code to linear value in Q(frac)
   function automatic longint srgb_decode(input longint k, input int ch, input int frac);
      longint m;
      longint u;
      longint sq;
      longint w;
      longint lin;
      m = (64'sd1 <<< ch) - 1;
      if (k * 64'sd1000000000 <= 64'sd40449936 * m)
         return udiv(((100 * k) <<< frac) + 646 * m, 1292 * m);
      u = udiv((1000 * k + 55 * m) <<< 30, 1055 * m);
      sq = mul30(u, u);
      w = fifth_root30(sq);
      lin = mul30(sq, w);
      return (lin + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
   endfunction

   // linear value in Q(frac), already within 0..1, to sRGB code
   function automatic longint srgb_encode(input longint y, input int ch, input int frac);
      longint m;
      longint one;
      longint c;
      longint s;
      longint q;
      longint z;
      longint num;
      m = (64'sd1 <<< ch) - 1;
      one = 64'sd1 <<< frac;
      if (y * 64'sd10000000 <= 64'sd31308 * one)
         return udiv(y * 1292 * m + 50 * one, 100 * one);
      c = cube_root30(y <<< (30 - frac));
      s = int_sqrt(c <<< 30);
      q = int_sqrt(s <<< 30);
      z = mul30(c, q);
      num = 1055 * z * m + 500 * Q30_ONE - 55 * m * Q30_ONE;
      if (num <= 0) return 0;
      num = udiv(num, 1000 * Q30_ONE);
      return (num > m) ? m : num;
   endfunction

   // smallest linear value that encodes to code k or above; one past 1.0 if none
   function automatic longint enc_thresh(input longint k, input int ch, input int frac);
      longint lo;
      longint hi;
      longint mid;
      longint one;
      one = 64'sd1 <<< frac;
      lo = 0;
      hi = one + 1;
      while (lo < hi) begin
         mid = (lo + hi) >>> 1;
         if (srgb_encode(mid, ch, frac) >= k) hi = mid; else lo = mid + 1;
      end
      return lo;
   endfunction

endpackage

// ----- hdl/ocb_if.sv -----
// Request and response channel interfaces of the Oklab color blend.
// Depends on ocb_pkg.
interface ocb_req_if import ocb_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int RATIO_BITS   = RATIO_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] src_red;
   logic [CHANNEL_BITS-1:0] src_green;
   logic [CHANNEL_BITS-1:0] src_blue;
   logic [CHANNEL_BITS-1:0] dst_red;
   logic [CHANNEL_BITS-1:0] dst_green;
   logic [CHANNEL_BITS-1:0] dst_blue;
   logic [RATIO_BITS:0]     blend_ratio;

   modport source(output valid, src_red, src_green, src_blue, dst_red, dst_green,
                  dst_blue, blend_ratio, input ready);
   modport sink(input valid, src_red, src_green, src_blue, dst_red, dst_green,
                dst_blue, blend_ratio, output ready);
endinterface

interface ocb_rsp_if import ocb_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;

   modport source(output valid, out_red, out_green, out_blue, input ready);
   modport sink(input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/ocb_matrix.sv -----
// 3x3 fixed-point matrix times vector: products stage, then sum and round stage.
// Depends on ocb_pkg.
module ocb_matrix import ocb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int MAT       = MAT_TO_LMS
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [FRAC_BITS+VAL_INT_BITS-1:0] x [3],
   output logic signed [FRAC_BITS+VAL_INT_BITS-1:0] y [3]
);
   localparam int V_W = FRAC_BITS + VAL_INT_BITS;
   localparam int C_W = FRAC_BITS + COEF_INT_BITS;
   localparam int P_W = V_W + C_W + 2;

   logic signed [P_W-1:0] prod_ff [9];
   logic signed [P_W-1:0] prod_in [9];
   logic signed [V_W-1:0] y_ff    [3];
   logic signed [V_W-1:0] y_in    [3];

   for (genvar i = 0; i < 3; i++) begin : g_prod_row
      for (genvar j = 0; j < 3; j++) begin : g_prod
         localparam logic signed [C_W-1:0] COEF = C_W'(coef_q(MAT, 3*i + j, FRAC_BITS));
         assign prod_in[3*i+j] = P_W'(COEF) * P_W'(x[j]);
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [P_W-1:0] acc;
      assign acc = prod_ff[3*r] + prod_ff[3*r+1] + prod_ff[3*r+2];
      assign y_in[r] = V_W'(rnd_shift(64'(acc), FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         y_ff    <= y_in;
      end
   end

   assign y = y_ff;
endmodule

// ----- hdl/ocb_cbrt.sv -----
// Pipelined fixed-point cube root, one result bit per two stages
// (square, then cube and compare). Depends on ocb_pkg.
module ocb_cbrt import ocb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [FRAC_BITS+1:0]   value,
   output logic [FRAC_BITS+1:0]   root
);
   localparam int R_W  = FRAC_BITS + 2;
   localparam int SQ_W = 2 * R_W - FRAC_BITS;
   localparam int CU_W = SQ_W + R_W;

   logic [R_W-1:0]  cand_ff [R_W];
   logic [SQ_W-1:0] sq_ff   [R_W];
   logic [R_W-1:0]  va_ff   [R_W];
   logic [R_W-1:0]  r_ff    [R_W];
   logic [R_W-1:0]  vb_ff   [R_W];

   for (genvar i = 0; i < R_W; i++) begin : g_step
      localparam logic [R_W-1:0] BITM = R_W'(1) << (R_W - 1 - i);
      logic [R_W-1:0]   r_prev;
      logic [R_W-1:0]   v_prev;
      logic [R_W-1:0]   cand_in;
      logic [2*R_W-1:0] sq_full;
      logic [CU_W-1:0]  cu_full;
      logic             keep;

      if (i == 0) begin : g_first
         assign r_prev = '0;
         assign v_prev = value;
      end else begin : g_next
         assign r_prev = r_ff[i-1];
         assign v_prev = vb_ff[i-1];
      end

      assign cand_in = r_prev | BITM;
      assign sq_full = (2*R_W)'(cand_in) * (2*R_W)'(cand_in);
      assign cu_full = CU_W'(sq_ff[i]) * CU_W'(cand_ff[i]);
      assign keep    = (cu_full >> FRAC_BITS) <= CU_W'(va_ff[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            cand_ff[i] <= cand_in;
            sq_ff[i]   <= sq_full[2*R_W-1:FRAC_BITS];
            va_ff[i]   <= v_prev;
            r_ff[i]    <= keep ? cand_ff[i] : (cand_ff[i] & ~BITM);
            vb_ff[i]   <= va_ff[i];
         end
      end
   end

   assign root = r_ff[R_W-1];
endmodule

// ----- hdl/ocb_lane.sv -----
// One pixel lane: sRGB decode table, LMS matrix, cube roots, Oklab matrix.
// Depends on ocb_pkg, ocb_matrix, ocb_cbrt.
module ocb_lane import ocb_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic [CHANNEL_BITS-1:0]                  pix [3],
   output logic signed [FRAC_BITS+VAL_INT_BITS-1:0] lab [3]
);
   localparam int V_W   = FRAC_BITS + VAL_INT_BITS;
   localparam int R_W   = FRAC_BITS + 2;
   localparam int NCODE = 1 << CHANNEL_BITS;

   logic [FRAC_BITS:0]    dec_tbl [NCODE];
   logic [FRAC_BITS:0]    lin_ff  [3];
   logic signed [V_W-1:0] lin     [3];
   logic signed [V_W-1:0] lms     [3];
   logic signed [V_W-1:0] root    [3];

   for (genvar k = 0; k < NCODE; k++) begin : g_dec
      localparam longint D = srgb_decode(k, CHANNEL_BITS, FRAC_BITS);
      assign dec_tbl[k] = (FRAC_BITS+1)'(D);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) lin_ff[c] <= dec_tbl[pix[c]];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [R_W-1:0] v;
      logic [R_W-1:0] r;
      assign lin[c] = signed'(V_W'(lin_ff[c]));
      // negative LMS roots to zero
      assign v = lms[c][V_W-1] ? '0 :
                 (lms[c] >= (V_W'(1) <<< R_W)) ? '1 : lms[c][R_W-1:0];
      ocb_cbrt #(.FRAC_BITS(FRAC_BITS)) u_cbrt (
         .clock(clock), .en(en), .value(v), .root(r));
      assign root[c] = signed'(V_W'(r));
   end

   ocb_matrix #(.FRAC_BITS(FRAC_BITS), .MAT(MAT_TO_LMS)) u_to_lms (
      .clock(clock), .en(en), .x(lin), .y(lms));
   ocb_matrix #(.FRAC_BITS(FRAC_BITS), .MAT(MAT_TO_LAB)) u_to_lab (
      .clock(clock), .en(en), .x(root), .y(lab));
endmodule

// ----- hdl/ocb_merge.sv -----
// Merge stage: blends the two lanes' Oklab values, returns to linear RGB,
// clamps and encodes by a pipelined threshold search. Depends on ocb_pkg,
// ocb_matrix.
module ocb_merge import ocb_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int RATIO_BITS   = RATIO_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     en,
   input  logic signed [FRAC_BITS+VAL_INT_BITS-1:0] src_lab [3],
   input  logic signed [FRAC_BITS+VAL_INT_BITS-1:0] dst_lab [3],
   input  logic [RATIO_BITS:0]                      ratio,
   output logic [CHANNEL_BITS-1:0]                  code [3]
);
   localparam int V_W   = FRAC_BITS + VAL_INT_BITS;
   localparam int B_W   = V_W + RATIO_BITS + 3;
   localparam int NCODE = 1 << CHANNEL_BITS;
   localparam logic signed [V_W-1:0] ONE_Q = V_W'(1) <<< FRAC_BITS;

   logic signed [B_W-1:0]   bprod_ff [3];
   logic signed [V_W-1:0]   srcd_ff  [3];
   logic signed [V_W-1:0]   mix_ff   [3];
   logic signed [V_W-1:0]   lmsr     [3];
   logic signed [V_W-1:0]   l_ff     [3];
   logic signed [V_W-1:0]   sq_ff    [3];
   logic signed [V_W-1:0]   cube_ff  [3];
   logic signed [V_W-1:0]   rgb      [3];
   logic [FRAC_BITS+1:0]    thr_tbl  [NCODE];

   for (genvar k = 0; k < NCODE; k++) begin : g_thr
      localparam longint T = enc_thresh(k, CHANNEL_BITS, FRAC_BITS);
      assign thr_tbl[k] = (FRAC_BITS+2)'(T);
   end

   for (genvar c = 0; c < 3; c++) begin : g_ch
      logic signed [V_W:0]     diff;
      logic signed [B_W-1:0]   bprod;
      logic signed [2*V_W-1:0] p_sq;
      logic signed [2*V_W-1:0] p_cu;
      logic [FRAC_BITS:0]      y;
      logic [CHANNEL_BITS-1:0] k_ff [CHANNEL_BITS];
      logic [FRAC_BITS:0]      y_ff [CHANNEL_BITS];

      assign diff  = (V_W+1)'(dst_lab[c]) - (V_W+1)'(src_lab[c]);
      assign bprod = B_W'(diff) * B_W'(signed'({1'b0, ratio}));
      assign p_sq  = (2*V_W)'(lmsr[c]) * (2*V_W)'(lmsr[c]);
      assign p_cu  = (2*V_W)'(sq_ff[c]) * (2*V_W)'(l_ff[c]);

      // out of gamut saturates
      assign y = rgb[c][V_W-1] ? '0 :
                 (rgb[c] > ONE_Q) ? (FRAC_BITS+1)'(ONE_Q) : rgb[c][FRAC_BITS:0];

      always_ff @(posedge clock) begin
         if (en) begin
            bprod_ff[c] <= bprod;
            srcd_ff[c]  <= src_lab[c];
            mix_ff[c]   <= srcd_ff[c] + V_W'(rnd_shift(64'(bprod_ff[c]), RATIO_BITS));
            sq_ff[c]    <= V_W'(rnd_shift(64'(p_sq), FRAC_BITS));
            l_ff[c]     <= lmsr[c];
            cube_ff[c]  <= V_W'(rnd_shift(64'(p_cu), FRAC_BITS));
         end
      end

      // largest code whose threshold does not exceed y, one bit per stage
      for (genvar j = 0; j < CHANNEL_BITS; j++) begin : g_srch
         localparam logic [CHANNEL_BITS-1:0] BITM =
            CHANNEL_BITS'(1) << (CHANNEL_BITS - 1 - j);
         logic [CHANNEL_BITS-1:0] k_prev;
         logic [FRAC_BITS:0]      y_prev;
         logic [CHANNEL_BITS-1:0] cand;
         if (j == 0) begin : g_first
            assign k_prev = '0;
            assign y_prev = y;
         end else begin : g_next
            assign k_prev = k_ff[j-1];
            assign y_prev = y_ff[j-1];
         end
         assign cand = k_prev | BITM;
         always_ff @(posedge clock) begin
            if (en) begin
               k_ff[j] <= (thr_tbl[cand] <= {1'b0, y_prev}) ? cand : k_prev;
               y_ff[j] <= y_prev;
            end
         end
      end

      assign code[c] = k_ff[CHANNEL_BITS-1];
   end

   ocb_matrix #(.FRAC_BITS(FRAC_BITS), .MAT(MAT_LAB_TO_LMS)) u_to_lms (
      .clock(clock), .en(en), .x(mix_ff), .y(lmsr));
   ocb_matrix #(.FRAC_BITS(FRAC_BITS), .MAT(MAT_LMS_TO_RGB)) u_to_rgb (
      .clock(clock), .en(en), .x(cube_ff), .y(rgb));
endmodule

// ----- hdl/oklab_color_blend_top.sv -----
// Oklab color blend, top level: two pixel lanes, merge stage, output queue.
// Depends on ocb_pkg, ocb_if, ocb_lane, ocb_merge.
//
// Usage:
//  req_chan carries a source pixel, a destination pixel and a blend ratio
//  (2^RATIO_BITS means all destination; larger values saturate to it).
//  rsp_chan returns one blended sRGB pixel per request transaction, in order.
//  The per-lane cube-root pipeline (two stages per root bit) dominates the
//  path from request transaction to the result showing in the output queue.
//  Throughput is one transaction per cycle. A two-entry output queue holds
//  finished results, so requests keep flowing while one result waits; only
//  when both entries are full and rsp_chan.ready is low does the whole
//  pipeline hold and req_chan.ready drop.
//  Reset (synchronous) empties the pipeline and the queue; no table setup
//  follows, the block takes requests on the first cycle after reset.
module oklab_color_blend_top import ocb_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int RATIO_BITS   = RATIO_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input logic     clock,
   input logic     reset,
   ocb_req_if.sink   req_chan,
   ocb_rsp_if.source rsp_chan
);
   localparam int V_W      = FRAC_BITS + VAL_INT_BITS;
   localparam int LANE_LAT = 2 * FRAC_BITS + 9;
   localparam int LAT      = LANE_LAT + 8 + CHANNEL_BITS;
   localparam int PIX_W    = 3 * CHANNEL_BITS;
   localparam logic [RATIO_BITS:0] RATIO_ONE = (RATIO_BITS+1)'(1) << RATIO_BITS;

   logic                    en;
   logic                    push;
   logic                    pop;
   logic [LAT-1:0]          vld_ff;
   logic [RATIO_BITS:0]     t_ff [LANE_LAT];
   logic [RATIO_BITS:0]     t_sat;
   logic [CHANNEL_BITS-1:0] src_pix [3];
   logic [CHANNEL_BITS-1:0] dst_pix [3];
   logic signed [V_W-1:0]   src_lab [3];
   logic signed [V_W-1:0]   dst_lab [3];
   logic [CHANNEL_BITS-1:0] code    [3];
   logic [PIX_W-1:0]        q0_ff, q0_in;
   logic [PIX_W-1:0]        q1_ff, q1_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [1:0]              wr_slot;

   assign en  = (cnt_ff != 2'd2) || rsp_chan.ready;
   assign req_chan.ready = en;
   assign push = en && vld_ff[LAT-1];
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   assign t_sat = (req_chan.blend_ratio > RATIO_ONE) ? RATIO_ONE : req_chan.blend_ratio;
   assign src_pix = '{req_chan.src_red, req_chan.src_green, req_chan.src_blue};
   assign dst_pix = '{req_chan.dst_red, req_chan.dst_green, req_chan.dst_blue};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= t_sat;
         for (int i = 1; i < LANE_LAT; i++) t_ff[i] <= t_ff[i-1];
      end
   end

   ocb_lane #(.CHANNEL_BITS(CHANNEL_BITS), .FRAC_BITS(FRAC_BITS)) u_src_lane (
      .clock(clock), .en(en), .pix(src_pix), .lab(src_lab));
   ocb_lane #(.CHANNEL_BITS(CHANNEL_BITS), .FRAC_BITS(FRAC_BITS)) u_dst_lane (
      .clock(clock), .en(en), .pix(dst_pix), .lab(dst_lab));

   ocb_merge #(.CHANNEL_BITS(CHANNEL_BITS), .RATIO_BITS(RATIO_BITS),
               .FRAC_BITS(FRAC_BITS)) u_merge (
      .clock(clock), .en(en), .src_lab(src_lab), .dst_lab(dst_lab),
      .ratio(t_ff[LANE_LAT-1]), .code(code));

   // two-entry output queue, head in slot 0
   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      wr_slot = cnt_ff - {1'b0, pop};
      if (pop) q0_in = q1_ff;
      if (push) begin
         if (wr_slot == 2'd0) q0_in = {code[0], code[1], code[2]};
         else                 q1_in = {code[0], code[1], code[2]};
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_chan.valid     = (cnt_ff != 2'd0);
   assign rsp_chan.out_red   = q0_ff[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
   assign rsp_chan.out_green = q0_ff[2*CHANNEL_BITS-1:CHANNEL_BITS];
   assign rsp_chan.out_blue  = q0_ff[CHANNEL_BITS-1:0];

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("output queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2 || pop)) else $error("output queue overflow");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff)) else $error("pipeline moved while stalled");
`endif
endmodule

// ----- dv/tb_oklab_color_blend_top.sv -----
// Testbench for oklab_color_blend_top: random and directed pixel pairs, with a bit-exact
// Oklab blend predictor and an in-order scoreboard. Depends on ocb_pkg, ocb_if and the RTL.
module tb_oklab_color_blend_top import ocb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_RANDOM  = 750;
   localparam int  DRAIN_WAIT  = 80;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  LONG_HOLD   = 300;

   typedef struct {
      bit [7:0] src_r, src_g, src_b;
      bit [7:0] dst_r, dst_g, dst_b;
      bit [8:0] ratio;
   } blend_req_type;

   typedef struct {
      bit [7:0] r, g, b;
   } pixel_type;

   class blend_scoreboard;
      pixel_type expected_pixels[$];
      int        errors;

      function longint rnd_half(longint v, int s);
         longint half;
         half = 64'sd1 <<< (s - 1);
         if (v >= 0) return (v + half) >>> s;
         return -((-v + half) >>> s);
      endfunction

      function longint coef_fix(int sel, int idx);
         longint c10;
         longint a;
         longint r;
         case (sel)
            MAT_TO_LMS:     c10 = TO_LMS_C[idx];
            MAT_TO_LAB:     c10 = TO_LAB_C[idx];
            MAT_LAB_TO_LMS: c10 = LAB_TO_LMS_C[idx];
            default:        c10 = LMS_TO_RGB_C[idx];
         endcase
         a = (c10 < 0) ? -c10 : c10;
         r = (a * 65536 + 64'sd5000000000) / 64'sd10000000000;
         return (c10 < 0) ? -r : r;
      endfunction

      function void mat_mul(int sel, longint x[3], output longint y[3]);
         longint acc;
         for (int i = 0; i < 3; i++) begin
            acc = coef_fix(sel, 3*i) * x[0] + coef_fix(sel, 3*i+1) * x[1]
                + coef_fix(sel, 3*i+2) * x[2];
            y[i] = rnd_half(acc, 16);
         end
      endfunction

      function longint q30_mul(longint a, longint b);
         return (a * b) >>> 30;
      endfunction

      // largest r with floored cube not above v, fb fraction bits
      function longint cbrt_floor(longint v, int fb, longint limit);
         longint lo;
         longint hi;
         longint mid;
         longint sq;
         lo = 0;
         hi = limit;
         while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >>> 1);
            sq = (mid * mid) >>> fb;
            if (((sq * mid) >>> fb) <= v) lo = mid; else hi = mid - 1;
         end
         return lo;
      endfunction

      function longint fifth_rt(longint v);
         longint lo;
         longint hi;
         longint mid;
         lo = 0;
         hi = 64'sd1 <<< 30;
         while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >>> 1);
            if (q30_mul(q30_mul(q30_mul(q30_mul(mid, mid), mid), mid), mid) <= v) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function longint sqrt_floor(longint v);
         longint unsigned lo;
         longint unsigned hi;
         longint unsigned mid;
         lo = 0;
         hi = 64'hFFFF_FFFF;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid <= longint'(v)) lo = mid; else hi = mid - 1;
         end
         return longint'(lo);
      endfunction

      function longint to_linear(longint k);
         longint u;
         longint sq;
         longint lin;
         if (k * 1000000000 <= 64'sd40449936 * 255)
            return ((100 * k) * 65536 + 646 * 255) / (1292 * 255);
         u = ((1000 * k + 55 * 255) <<< 30) / (1055 * 255);
         sq = q30_mul(u, u);
         lin = q30_mul(sq, fifth_rt(sq));
         return (lin + (64'sd1 <<< 13)) >>> 14;
      endfunction

      function bit [7:0] to_code(longint y);
         longint c;
         longint s;
         longint q;
         longint z;
         longint num;
         if (y < 0) y = 0;
         if (y > 65536) y = 65536;
         if (y * 10000000 <= 64'sd31308 * 65536)
            return 8'((y * 1292 * 255 + 50 * 65536) / (100 * 65536));
         c = cbrt_floor(y <<< 14, 30, 64'sd1 <<< 30);
         s = sqrt_floor(c <<< 30);
         q = sqrt_floor(s <<< 30);
         z = q30_mul(c, q);
         num = 1055 * z * 255 + 500 * (64'sd1 <<< 30) - 55 * 255 * (64'sd1 <<< 30);
         if (num <= 0) return 0;
         num = num / (1000 * (64'sd1 <<< 30));
         return (num > 255) ? 8'd255 : 8'(num);
      endfunction

      function void rgb_to_lab(bit [7:0] r, bit [7:0] g, bit [7:0] b, output longint lab[3]);
         longint lin[3];
         longint lms[3];
         longint root[3];
         lin[0] = to_linear(r);
         lin[1] = to_linear(g);
         lin[2] = to_linear(b);
         mat_mul(MAT_TO_LMS, lin, lms);
         for (int i = 0; i < 3; i++)
            root[i] = cbrt_floor((lms[i] < 0) ? 0 : lms[i], 16, 64'sd1 <<< 18);
         mat_mul(MAT_TO_LAB, root, lab);
      endfunction

      function pixel_type blend_pixel(blend_req_type rq);
         longint src[3];
         longint dst[3];
         longint mix[3];
         longint lms[3];
         longint cube[3];
         longint rgb[3];
         longint t;
         longint sq;
         pixel_type p;
         t = (rq.ratio > 256) ? 256 : rq.ratio;
         rgb_to_lab(rq.src_r, rq.src_g, rq.src_b, src);
         rgb_to_lab(rq.dst_r, rq.dst_g, rq.dst_b, dst);
         for (int i = 0; i < 3; i++) mix[i] = src[i] + rnd_half((dst[i] - src[i]) * t, 8);
         mat_mul(MAT_LAB_TO_LMS, mix, lms);
         for (int i = 0; i < 3; i++) begin
            sq = rnd_half(lms[i] * lms[i], 16);
            cube[i] = rnd_half(sq * lms[i], 16);
         end
         mat_mul(MAT_LMS_TO_RGB, cube, rgb);
         p.r = to_code(rgb[0]);
         p.g = to_code(rgb[1]);
         p.b = to_code(rgb[2]);
         return p;
      endfunction

      function void note_request(blend_req_type rq);
         expected_pixels.push_back(blend_pixel(rq));
      endfunction

      function void check_pixel(pixel_type act);
         pixel_type exp_p;
         if (expected_pixels.size() == 0) begin
            $error("result transaction with no expected pixel: %0d %0d %0d",
                   act.r, act.g, act.b);
            errors++;
            return;
         end
         exp_p = expected_pixels.pop_front();
         if (act.r !== exp_p.r) begin
            $error("out_red expected %0d actual %0d", exp_p.r, act.r);
            errors++;
         end
         if (act.g !== exp_p.g) begin
            $error("out_green expected %0d actual %0d", exp_p.g, act.g);
            errors++;
         end
         if (act.b !== exp_p.b) begin
            $error("out_blue expected %0d actual %0d", exp_p.b, act.b);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   bit   no_idle = 1'b0;
   bit   hold_request = 1'b0;
   blend_scoreboard pixel_sb = new();

   ocb_req_if req_chan();
   ocb_rsp_if rsp_chan();

   oklab_color_blend_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // transaction monitors; pre-edge values are seen here
   always @(posedge clock) begin
      blend_req_type rq;
      pixel_type     px;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            rq.src_r = req_chan.src_red;
            rq.src_g = req_chan.src_green;
            rq.src_b = req_chan.src_blue;
            rq.dst_r = req_chan.dst_red;
            rq.dst_g = req_chan.dst_green;
            rq.dst_b = req_chan.dst_blue;
            rq.ratio = req_chan.blend_ratio;
            pixel_sb.note_request(rq);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            px.r = rsp_chan.out_red;
            px.g = rsp_chan.out_green;
            px.b = rsp_chan.out_blue;
            pixel_sb.check_pixel(px);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // receiver: random stalls, one long hold on request
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (no_idle) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
   end

   task automatic send_request(blend_req_type rq);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.src_red     <= rq.src_r;
      req_chan.src_green   <= rq.src_g;
      req_chan.src_blue    <= rq.src_b;
      req_chan.dst_red     <= rq.dst_r;
      req_chan.dst_green   <= rq.dst_g;
      req_chan.dst_blue    <= rq.dst_b;
      req_chan.blend_ratio <= rq.ratio;
      do @(posedge clock); while (!req_chan.ready);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pair(bit [7:0] sr, bit [7:0] sg, bit [7:0] sb,
                            bit [7:0] dr, bit [7:0] dg, bit [7:0] db, bit [8:0] t);
      blend_req_type rq;
      rq = '{sr, sg, sb, dr, dg, db, t};
      send_request(rq);
   endtask

   function automatic bit [7:0] rand_code();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'd255;
      if (roll == 2) return 8'($urandom_range(12));   // linear segment of the curve and the codes just above it
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random();
      bit [8:0] t;
      t = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 257)) : 9'($urandom_range(256));
      send_pair(rand_code(), rand_code(), rand_code(),
                rand_code(), rand_code(), rand_code(), t);
   endtask

   task automatic wait_drained();
      while (pixel_sb.expected_pixels.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.src_red = '0;
      req_chan.src_green = '0;
      req_chan.src_blue = '0;
      req_chan.dst_red = '0;
      req_chan.dst_green = '0;
      req_chan.dst_blue = '0;
      req_chan.blend_ratio = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, saturating ratio, gamut corners, linear segment
      send_pair(0, 0, 0, 0, 0, 0, 0);
      send_pair(255, 255, 255, 255, 255, 255, 256);
      send_pair(0, 0, 0, 255, 255, 255, 0);
      send_pair(0, 0, 0, 255, 255, 255, 128);
      send_pair(0, 0, 0, 255, 255, 255, 256);
      send_pair(0, 0, 0, 255, 255, 255, 257);
      send_pair(255, 255, 255, 0, 0, 0, 511);
      send_pair(255, 0, 0, 0, 255, 0, 128);
      send_pair(0, 0, 255, 255, 255, 0, 128);
      send_pair(255, 0, 0, 0, 0, 255, 64);
      send_pair(0, 255, 0, 255, 0, 255, 192);
      send_pair(10, 10, 10, 11, 11, 11, 1);
      send_pair(1, 2, 3, 250, 128, 5, 255);
      send_pair(170, 85, 170, 85, 170, 85, 384);
      send_pair(255, 255, 0, 0, 255, 255, 100);
      send_pair(11, 0, 255, 255, 0, 11, 200);

      for (int i = 0; i < 300; i++) send_random();
      no_idle = 1'b1;
      for (int i = 0; i < 150; i++) send_random();
      no_idle = 1'b0;
      // receiver holds off while requests keep coming, so the block backs up
      hold_request = 1'b1;
      for (int i = 0; i < 100; i++) send_random();
      req_chan.valid <= 1'b0;
      wait_drained();
      for (int i = 0; i < NUM_RANDOM - 550; i++) send_random();
      req_chan.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pixel_sb.errors == 0 && pixel_sb.expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hdl/ocb_pkg.sv
hdl/ocb_if.sv
hdl/ocb_matrix.sv
hdl/ocb_cbrt.sv
hdl/ocb_lane.sv
hdl/ocb_merge.sv
hdl/oklab_color_blend_top.sv
dv/tb_oklab_color_blend_top.sv
